// ----- hdl/slwc_pkg.sv -----
`timescale 1ns / 1ps

package slwc_pkg;

   // list geometry
   localparam int DEPTH       = 16;
   localparam int VALUE_WIDTH = 32;
   localparam int IDX_W       = $clog2(DEPTH);
   localparam int CNT_W       = $clog2(DEPTH + 1);
   localparam int CUR_W       = $clog2(DEPTH + 2);
   localparam int OP_W        = 3;

   // operation codes, code 7 is unused and refused
   typedef enum logic [OP_W-1:0] {
      OP_INSERT  = 3'd0,
      OP_FIRST   = 3'd1,
      OP_LAST    = 3'd2,
      OP_ADVANCE = 3'd3,
      OP_RETREAT = 3'd4,
      OP_DELETE  = 3'd5,
      OP_READ    = 3'd6
   } op_type;

   // controller states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_RESP
   } state_type;

   // commands from controller to datapath
   typedef struct packed {
      logic capture;
      logic execute;
   } ctrl_cmd_type;

endpackage

// ----- hdl/slwc_if.sv -----
`timescale 1ns / 1ps

// operation channel
interface slwc_req_if;
   logic                                 valid;
   logic                                 ready;
   logic [slwc_pkg::OP_W-1:0]            op;
   logic signed [slwc_pkg::VALUE_WIDTH-1:0] value_in;

   modport source (output valid, output op, output value_in, input ready);
   modport sink   (input valid, input op, input value_in, output ready);
endinterface

// result channel
interface slwc_rsp_if;
   logic                                 valid;
   logic                                 ready;
   logic signed [slwc_pkg::VALUE_WIDTH-1:0] cursor_value;
   logic                                 at_first;
   logic                                 at_last;
   logic                                 is_empty;
   logic [slwc_pkg::CNT_W-1:0]           entry_count;
   logic                                 error;

   modport source (output valid, output cursor_value, output at_first, output at_last,
                   output is_empty, output entry_count, output error, input ready);
   modport sink   (input valid, input cursor_value, input at_first, input at_last,
                   input is_empty, input entry_count, input error, output ready);
endinterface

// ----- hdl/slwc_controller.sv -----
`timescale 1ns / 1ps

module slwc_controller (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output slwc_pkg::ctrl_cmd_type cmd
);

   slwc_pkg::state_type state_ff;
   slwc_pkg::state_type state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= slwc_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         slwc_pkg::ST_IDLE: begin
            if (req_valid) state_in = slwc_pkg::ST_EXEC;
         end
         slwc_pkg::ST_EXEC: begin
            state_in = slwc_pkg::ST_RESP;
         end
         slwc_pkg::ST_RESP: begin
            if (rsp_ready) state_in = slwc_pkg::ST_IDLE;
         end
         default: begin
            state_in = slwc_pkg::ST_IDLE;
         end
      endcase
   end

   // outputs, no item is taken while reset is held
   always_comb begin
      req_ready   = 1'b0;
      rsp_valid   = 1'b0;
      cmd.capture = 1'b0;
      cmd.execute = 1'b0;
      unique case (state_ff)
         slwc_pkg::ST_IDLE: begin
            req_ready   = !reset;
            cmd.capture = req_valid && !reset;
         end
         slwc_pkg::ST_EXEC: begin
            cmd.execute = 1'b1;
         end
         slwc_pkg::ST_RESP: begin
            rsp_valid = 1'b1;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

endmodule

// ----- hdl/slwc_datapath.sv -----
`timescale 1ns / 1ps

module slwc_datapath (
   input  logic                                   clock,
   input  logic                                   reset,
   input  slwc_pkg::ctrl_cmd_type                 cmd,
   input  logic [slwc_pkg::OP_W-1:0]              op,
   input  logic signed [slwc_pkg::VALUE_WIDTH-1:0] value_in,
   output logic signed [slwc_pkg::VALUE_WIDTH-1:0] cursor_value,
   output logic                                   at_first,
   output logic                                   at_last,
   output logic                                   is_empty,
   output logic [slwc_pkg::CNT_W-1:0]             entry_count,
   output logic                                   error
);

   localparam int DEPTH = slwc_pkg::DEPTH;
   localparam int VW    = slwc_pkg::VALUE_WIDTH;
   localparam int IDX_W = slwc_pkg::IDX_W;
   localparam int CNT_W = slwc_pkg::CNT_W;
   localparam int CUR_W = slwc_pkg::CUR_W;

   slwc_pkg::op_type       op_ff;
   logic signed [VW-1:0]   value_ff;
   logic signed [VW-1:0]   entries_ff [DEPTH];
   logic signed [VW-1:0]   entries_in [DEPTH];
   logic [CNT_W-1:0]       count_ff;
   logic [CNT_W-1:0]       count_in;
   logic [CUR_W-1:0]       cursor_ff;
   logic [CUR_W-1:0]       cursor_in;
   logic                   error_ff;
   logic                   error_in;

   logic [DEPTH-1:0]       lt;
   logic [DEPTH-1:0]       lt_prev;
   logic signed [VW-1:0]   entries_up [DEPTH];
   logic signed [VW-1:0]   entries_dn [DEPTH];
   logic [CUR_W-1:0]       ins_pos;
   logic [CUR_W-1:0]       cur_m1;
   logic [IDX_W-1:0]       rd_idx;
   logic [CUR_W-1:0]       count_ext;
   logic                   on_entry;
   logic                   full;

   // operation capture
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff    <= slwc_pkg::op_type'(op);
         value_ff <= value_in;
      end
   end

   // cell compare against the new value, and neighbour views for shifting
   always_comb begin
      for (int i = 0; i < DEPTH; i++) begin
         lt[i] = (CNT_W'(i) < count_ff) && (entries_ff[i] < value_ff);
      end
      lt_prev       = {lt[DEPTH-2:0], 1'b1};
      entries_up[0] = value_ff;
      for (int i = 1; i < DEPTH; i++) begin
         entries_up[i] = entries_ff[i-1];
      end
      for (int i = 0; i < DEPTH - 1; i++) begin
         entries_dn[i] = entries_ff[i+1];
      end
      entries_dn[DEPTH-1] = entries_ff[DEPTH-1];
      ins_pos = CUR_W'($countones(lt));
   end

   // cursor decode
   assign count_ext = CUR_W'(count_ff);
   assign cur_m1    = cursor_ff - CUR_W'(1);
   assign rd_idx    = cur_m1[IDX_W-1:0];
   assign on_entry  = (cursor_ff != '0) && (cursor_ff <= count_ext);
   assign full      = (count_ff == CNT_W'(DEPTH));

   // operation execute
   always_comb begin
      entries_in = entries_ff;
      count_in   = count_ff;
      cursor_in  = cursor_ff;
      error_in   = error_ff;
      if (cmd.execute) begin
         error_in = 1'b0;
         unique case (op_ff)
            slwc_pkg::OP_INSERT: begin
               if (full) begin
                  error_in = 1'b1;
               end else begin
                  for (int i = 0; i < DEPTH; i++) begin
                     if (!lt[i]) begin
                        entries_in[i] = lt_prev[i] ? value_ff : entries_up[i];
                     end
                  end
                  count_in  = count_ff + CNT_W'(1);
                  cursor_in = ins_pos;
               end
            end
            slwc_pkg::OP_FIRST: begin
               cursor_in = CUR_W'(1);
            end
            slwc_pkg::OP_LAST: begin
               cursor_in = count_ext;
            end
            slwc_pkg::OP_ADVANCE: begin
               if (cursor_ff > count_ext) error_in = 1'b1;
               else cursor_in = cursor_ff + CUR_W'(1);
            end
            slwc_pkg::OP_RETREAT: begin
               if (cursor_ff == '0) error_in = 1'b1;
               else cursor_in = cur_m1;
            end
            slwc_pkg::OP_DELETE: begin
               if (!on_entry) begin
                  error_in = 1'b1;
               end else begin
                  for (int i = 0; i < DEPTH; i++) begin
                     if (IDX_W'(i) >= rd_idx) entries_in[i] = entries_dn[i];
                  end
                  count_in = count_ff - CNT_W'(1);
               end
            end
            slwc_pkg::OP_READ: begin
               error_in = !on_entry;
            end
            default: begin
               error_in = 1'b1;
            end
         endcase
      end
   end

   // list cells
   always_ff @(posedge clock) begin
      entries_ff <= entries_in;
   end

   // list control state
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         cursor_ff <= '0;
         error_ff  <= 1'b0;
      end else begin
         count_ff  <= count_in;
         cursor_ff <= cursor_in;
         error_ff  <= error_in;
      end
   end

   // result fields
   assign cursor_value = on_entry ? entries_ff[rd_idx] : '0;
   assign at_first     = (count_ff != '0) && (cursor_ff == CUR_W'(1));
   assign at_last      = (count_ff != '0) && (cursor_ff == count_ext);
   assign is_empty     = (count_ff == '0);
   assign entry_count  = count_ff;
   assign error        = error_ff;

endmodule

// ----- hdl/sorted_list_with_cursor.sv -----
`timescale 1ns / 1ps

// Sorted list of up to 16 signed 32-bit values with a cursor that stands on
// the head marker, an entry, or the tail marker. Each item on req_ch is one
// operation (insert, first, last, advance, retreat, delete, read) and gives
// exactly one item on rsp_ch, holding the state after that operation. One
// item is handled at a time: capture, an execute step in which all cells
// compare and shift in parallel, then the result is held until taken; the
// next item is accepted only once the result has been taken. Refused
// operations flag error and change nothing.
module sorted_list_with_cursor (
   input  logic     clock,
   input  logic     reset,
   slwc_req_if.sink   req_ch,
   slwc_rsp_if.source rsp_ch
);

   slwc_pkg::ctrl_cmd_type cmd;

   // sequencing
   slwc_controller u_controller (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .cmd       (cmd)
   );

   // list cells and cursor
   slwc_datapath u_datapath (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .op           (req_ch.op),
      .value_in     (req_ch.value_in),
      .cursor_value (rsp_ch.cursor_value),
      .at_first     (rsp_ch.at_first),
      .at_last      (rsp_ch.at_last),
      .is_empty     (rsp_ch.is_empty),
      .entry_count  (rsp_ch.entry_count),
      .error        (rsp_ch.error)
   );

endmodule

// ----- hdl/slwc_checker.sv -----
`timescale 1ns / 1ps

module slwc_checker (
   input logic                                   clock,
   input logic                                   reset,
   input logic                                   req_valid,
   input logic                                   req_ready,
   input logic                                   rsp_valid,
   input logic                                   rsp_ready,
   input logic signed [slwc_pkg::VALUE_WIDTH-1:0] cursor_value,
   input logic                                   at_first,
   input logic                                   at_last,
   input logic                                   is_empty,
   input logic [slwc_pkg::CNT_W-1:0]             entry_count
);

   // an empty list shows no entry under the cursor
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && is_empty) |-> (!at_first && !at_last && cursor_value == '0))
      else $error("empty list reports a cursor entry");

   // count never exceeds capacity
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (entry_count <= slwc_pkg::CNT_W'(slwc_pkg::DEPTH)))
      else $error("entry count beyond capacity");

   // one result per item: no new item while a result is pending
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (!req_ready && !rsp_valid))
      else $error("item accepted or result shown too early");

   // a taken result is not repeated
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready) |=> !rsp_valid)
      else $error("result repeated");

   // a stalled result holds
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(cursor_value)
                                      && $stable(entry_count)))
      else $error("stalled result changed");

endmodule

bind sorted_list_with_cursor slwc_checker u_slwc_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_ch.valid),
   .req_ready    (req_ch.ready),
   .rsp_valid    (rsp_ch.valid),
   .rsp_ready    (rsp_ch.ready),
   .cursor_value (rsp_ch.cursor_value),
   .at_first     (rsp_ch.at_first),
   .at_last      (rsp_ch.at_last),
   .is_empty     (rsp_ch.is_empty),
   .entry_count  (rsp_ch.entry_count)
);
